[hdl/tsir_pkg.sv]
// ----------------------------------------------------------------------------
// TCP segment interval record - shared types and constants
// Header item and record item layouts, register reset value.
// ----------------------------------------------------------------------------
package tsir_pkg;

  localparam logic [15:0] ACK_CAP_RESET = 16'd7500;

  typedef struct packed {
    logic        direction;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic        ack_flag;
    logic        syn_flag;
    logic        fin_flag;
    logic [3:0]  ip_header_words;
    logic [3:0]  tcp_header_words;
    logic [15:0] payload_bytes;
    logic [47:0] arrival_time;
  } tsir_hdr_t;

  typedef struct packed {
    logic        record_direction;
    logic [16:0] segment_size;
    logic [15:0] new_ack_bytes;
    logic [47:0] gap_time;
    logic [16:0] sender_mss;
    logic [16:0] peer_mss;
  } tsir_rec_t;

endpackage

[hdl/tsir_hdr_if.sv]
// ----------------------------------------------------------------------------
// Header channel
// Valid/ready channel carrying the parsed header fields of one packet.
// ----------------------------------------------------------------------------
interface tsir_hdr_if;
  import tsir_pkg::*;

  logic      valid;
  logic      ready;
  tsir_hdr_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/tsir_rec_if.sv]
// ----------------------------------------------------------------------------
// Record channel
// Valid/ready channel carrying one interval record.
// ----------------------------------------------------------------------------
interface tsir_rec_if;
  import tsir_pkg::*;

  logic      valid;
  logic      ready;
  tsir_rec_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/tsir_in_stage.sv]
// ----------------------------------------------------------------------------
// Input register
// Captures one header transfer; refills in the cycle it is consumed.
// ----------------------------------------------------------------------------
module tsir_in_stage (
  input  logic                clk,
  input  logic                rst,
  tsir_hdr_if.sink            hdr,
  input  logic                advance,
  output logic                item_valid,
  output tsir_pkg::tsir_hdr_t item
);
  import tsir_pkg::*;

  logic vld;

  assign hdr.ready  = !vld || advance;
  assign item_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (hdr.valid && hdr.ready) begin
      vld <= 1'b1;
    end else if (advance) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr.valid && hdr.ready) begin
      item <= hdr.data;
    end
  end
endmodule

[hdl/tsir_core.sv]
// ----------------------------------------------------------------------------
// Record datapath and per-direction state
// Segment size, relative ack advance, gap and running max segment.
// ----------------------------------------------------------------------------
module tsir_core (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         ack_cap,
  input  logic                update,
  input  tsir_pkg::tsir_hdr_t item,
  output tsir_pkg::tsir_rec_t rec
);
  import tsir_pkg::*;

  typedef struct packed {
    logic        base_valid;
    logic [31:0] base_seq;
    logic        prev_valid;
    logic        prev_had_ack;
    logic [31:0] prev_rel_ack;
    logic [47:0] prev_time;
    logic [16:0] max_segment;
  } tsir_dir_t;

  tsir_dir_t st [2];
  tsir_dir_t st_next [2];
  tsir_dir_t cur, oth, cur_next, oth_next;

  logic [31:0] oth_base;
  logic [31:0] rel_ack;
  logic [31:0] adv;
  logic [4:0]  hdr_words;
  logic [16:0] size;
  logic [15:0] new_ack;
  logic [47:0] gap;

  always_comb begin
    cur = item.direction ? st[1] : st[0];
    oth = item.direction ? st[0] : st[1];

    hdr_words = {1'b0, item.ip_header_words} + {1'b0, item.tcp_header_words};
    size = {1'b0, item.payload_bytes} + {16'd0, item.syn_flag}
         + {16'd0, item.fin_flag} + {10'd0, hdr_words, 2'b00};

    // a packet carrying ACK pins the peer's base if not yet known
    oth_base = (item.ack_flag && !oth.base_valid) ? item.ack_number : oth.base_seq;
    rel_ack  = item.ack_number - oth_base;
    adv      = rel_ack - cur.prev_rel_ack;

    new_ack = '0;
    gap     = '0;
    if (cur.prev_valid) begin
      if (item.ack_flag && cur.prev_had_ack && (rel_ack > cur.prev_rel_ack) &&
          (adv < {16'd0, ack_cap})) begin
        new_ack = adv[15:0];
      end
      gap = item.arrival_time - cur.prev_time;
    end

    cur_next              = cur;
    cur_next.base_valid   = 1'b1;
    cur_next.base_seq     = cur.base_valid ? cur.base_seq : item.seq_number;
    cur_next.prev_valid   = 1'b1;
    cur_next.prev_had_ack = item.ack_flag;
    cur_next.prev_rel_ack = rel_ack;
    cur_next.prev_time    = item.arrival_time;
    cur_next.max_segment  = (size > cur.max_segment) ? size : cur.max_segment;

    oth_next            = oth;
    oth_next.base_valid = oth.base_valid || item.ack_flag;
    oth_next.base_seq   = oth_base;

    st_next[0] = item.direction ? oth_next : cur_next;
    st_next[1] = item.direction ? cur_next : oth_next;

    rec.record_direction = item.direction;
    rec.segment_size     = size;
    rec.new_ack_bytes    = new_ack;
    rec.gap_time         = gap;
    rec.sender_mss       = cur_next.max_segment;
    rec.peer_mss         = oth.max_segment;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0] <= '0;
      st[1] <= '0;
    end else if (update) begin
      st[0] <= st_next[0];
      st[1] <= st_next[1];
    end
  end
endmodule

[hdl/tsir_out_stage.sv]
// ----------------------------------------------------------------------------
// Result register
// Holds one record until the sink takes it.
// ----------------------------------------------------------------------------
module tsir_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  tsir_pkg::tsir_rec_t rec_in,
  output logic                free,
  tsir_rec_if.source          rec
);
  import tsir_pkg::*;

  logic vld;

  assign free      = !vld || rec.ready;
  assign rec.valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= 1'b1;
    end else if (rec.ready) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec.data <= rec_in;
    end
  end
endmodule

[hdl/tcp_segment_interval_record_unit.sv]
// ----------------------------------------------------------------------------
// TCP segment interval record unit
// Path: the header is captured in the input register, the record is formed
// combinationally and loaded into the result register for the sink.
// Throughput: one header per cycle while the result register is free;
// direction state is read and written between input and result registers.
// Reset: synchronous; clears all direction state, ack_cap returns to 7500.
// ----------------------------------------------------------------------------
module tcp_segment_interval_record_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        ack_cap_we,
  input  logic [15:0] ack_cap_wdata,
  tsir_hdr_if.sink    hdr,
  tsir_rec_if.source  rec
);
  import tsir_pkg::*;

  logic [15:0] ack_cap_reg;
  logic        item_valid;
  tsir_hdr_t   item;
  tsir_rec_t   rec_comb;
  logic        out_free;
  logic        advance;

  assign advance = item_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_cap_reg <= ACK_CAP_RESET;
    end else if (ack_cap_we) begin
      ack_cap_reg <= ack_cap_wdata;
    end
  end

  tsir_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .hdr        (hdr),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  tsir_core u_core (
    .clk     (clk),
    .rst     (rst),
    .ack_cap (ack_cap_reg),
    .update  (advance),
    .item    (item),
    .rec     (rec_comb)
  );

  tsir_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (advance),
    .rec_in (rec_comb),
    .free   (out_free),
    .rec    (rec)
  );
endmodule

[tb/tsir_record_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Interval record checker
// Watches the header and record channels, predicts each record from its own
// copy of the per-direction connection state and the ack cap, and compares
// every record field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tsir_record_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        ack_cap_we,
  input  logic [15:0] ack_cap_wdata,
  tsir_hdr_if         hdr,
  tsir_rec_if         rec,
  output int          fail_count,
  output int          pending
);
  import tsir_pkg::*;

  logic [15:0] ack_cap_shadow;
  logic        seq_base_known [2];
  logic [31:0] seq_base [2];
  logic        last_seen [2];
  logic        last_had_ack [2];
  logic [31:0] last_rel_ack [2];
  logic [47:0] last_stamp [2];
  logic [16:0] peak_size [2];

  tsir_rec_t records_due [$];

  initial fail_count = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] record mismatch, %s: got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic clear_connection();
    ack_cap_shadow = ACK_CAP_RESET;
    for (int d = 0; d < 2; d++) begin
      seq_base_known[d] = 1'b0;
      seq_base[d]       = '0;
      last_seen[d]      = 1'b0;
      last_had_ack[d]   = 1'b0;
      last_rel_ack[d]   = '0;
      last_stamp[d]     = '0;
      peak_size[d]      = '0;
    end
  endtask

  // Updates the connection state with one header and builds its record.
  task automatic predict_record(input tsir_hdr_t h, output tsir_rec_t r);
    logic        d;
    logic        o;
    logic [31:0] sum;
    logic [31:0] rel_ack;
    logic [31:0] advance;
    logic [15:0] acked;
    logic [47:0] gap;
    d     = h.direction;
    o     = ~h.direction;
    acked = '0;
    gap   = '0;
    if (!seq_base_known[d]) begin
      seq_base[d]       = h.seq_number;
      seq_base_known[d] = 1'b1;
    end
    if (h.ack_flag && !seq_base_known[o]) begin
      seq_base[o]       = h.ack_number;
      seq_base_known[o] = 1'b1;
    end
    sum = 32'(h.payload_bytes) + 32'(h.syn_flag) + 32'(h.fin_flag)
        + 32'd4 * (32'(h.ip_header_words) + 32'(h.tcp_header_words));
    rel_ack = h.ack_number - seq_base[o];
    if (last_seen[d]) begin
      // unsigned compare: a wrapped-back ack counts as no advance
      if (h.ack_flag && last_had_ack[d] && rel_ack > last_rel_ack[d]) begin
        advance = rel_ack - last_rel_ack[d];
        if (advance < 32'(ack_cap_shadow))
          acked = advance[15:0];
      end
      gap = h.arrival_time - last_stamp[d];
    end
    last_seen[d]    = 1'b1;
    last_had_ack[d] = h.ack_flag;
    last_rel_ack[d] = rel_ack;
    last_stamp[d]   = h.arrival_time;
    if (sum[16:0] > peak_size[d])
      peak_size[d] = sum[16:0];
    r.record_direction = d;
    r.segment_size     = sum[16:0];
    r.new_ack_bytes    = acked;
    r.gap_time         = gap;
    r.sender_mss       = peak_size[d];
    r.peer_mss         = peak_size[o];
  endtask

  always @(posedge clk) begin
    tsir_rec_t want;
    tsir_rec_t got;
    if (rst) begin
      clear_connection();
      records_due.delete();
      pending = 0;
    end else begin
      if (ack_cap_we)
        ack_cap_shadow = ack_cap_wdata;
      if (hdr.valid && hdr.ready) begin
        predict_record(hdr.data, want);
        records_due = {records_due, want};
      end
      if (rec.valid && rec.ready) begin
        got = rec.data;
        if (records_due.size() == 0) begin
          report_mismatch("record with none expected", 64'(got.segment_size), 64'd0);
        end else begin
          want = records_due.pop_front();
          if (got.record_direction !== want.record_direction)
            report_mismatch("record_direction", 64'(got.record_direction),
                            64'(want.record_direction));
          if (got.segment_size !== want.segment_size)
            report_mismatch("segment_size", 64'(got.segment_size), 64'(want.segment_size));
          if (got.new_ack_bytes !== want.new_ack_bytes)
            report_mismatch("new_ack_bytes", 64'(got.new_ack_bytes), 64'(want.new_ack_bytes));
          if (got.gap_time !== want.gap_time)
            report_mismatch("gap_time", 64'(got.gap_time), 64'(want.gap_time));
          if (got.sender_mss !== want.sender_mss)
            report_mismatch("sender_mss", 64'(got.sender_mss), 64'(want.sender_mss));
          if (got.peer_mss !== want.peer_mss)
            report_mismatch("peer_mss", 64'(got.peer_mss), 64'(want.peer_mss));
        end
      end
      pending = records_due.size();
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TCP segment interval record unit testbench
// Drives packet headers of one connection (directed corner cases, then
// random well-formed traffic mixed with noise) under several ack cap
// settings, with random idling on both channels, a long record hold-off
// and a stretch at full rate. The checker module does the comparison.
// ----------------------------------------------------------------------------
module testbench;
  import tsir_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 250;

  localparam logic [2:0] F_NONE = 3'b000;
  localparam logic [2:0] F_ACK  = 3'b100;
  localparam logic [2:0] F_SYN  = 3'b010;
  localparam logic [2:0] F_FIN  = 3'b001;

  logic        clk;
  logic        rst;
  logic        ack_cap_we;
  logic [15:0] ack_cap_wdata;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;

  bit steady   = 1'b0;  // no idling on either side
  bit hold_req = 1'b0;  // receiver holds off for HOLD_CYCLES

  // traffic generator state: next raw sequence number per side, clock
  logic [31:0] snd_next [2];
  logic [47:0] clock_us;

  tsir_hdr_if hdr_ch ();
  tsir_rec_if rec_ch ();

  tcp_segment_interval_record_unit dut (
    .clk           (clk),
    .rst           (rst),
    .ack_cap_we    (ack_cap_we),
    .ack_cap_wdata (ack_cap_wdata),
    .hdr           (hdr_ch),
    .rec           (rec_ch)
  );

  tsir_record_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .ack_cap_we    (ack_cap_we),
    .ack_cap_wdata (ack_cap_wdata),
    .hdr           (hdr_ch),
    .rec           (rec_ch),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tcp_segment_interval_record_unit test failed");
      $finish;
    end
  end

  // record side: random stalls, or a long hold-off counted here
  initial begin
    int held;
    rec_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        rec_ch.ready <= 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++)
          @(posedge clk);
        hold_req = 1'b0;
      end else begin
        rec_ch.ready <= steady || ($urandom_range(99) >= 32);
      end
    end
  end

  function automatic tsir_hdr_t hdr_item(input int dir, input logic [31:0] seq,
                                         input logic [31:0] ack, input logic [2:0] flags,
                                         input int iphw, input int tcphw,
                                         input int payload,
                                         input logic [47:0] stamp);
    tsir_hdr_t h;
    h.direction        = 1'(dir);
    h.seq_number       = seq;
    h.ack_number       = ack;
    h.ack_flag         = flags[2];
    h.syn_flag         = flags[1];
    h.fin_flag         = flags[0];
    h.ip_header_words  = 4'(iphw);
    h.tcp_header_words = 4'(tcphw);
    h.payload_bytes    = 16'(payload);
    h.arrival_time     = stamp;
    return h;
  endfunction

  // Mostly packets of a plausible connection, some raw noise.
  function automatic tsir_hdr_t traffic_item();
    tsir_hdr_t    h;
    logic         d;
    logic [159:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
    h = noise[$bits(tsir_hdr_t)-1:0];
    if ($urandom_range(99) < 15)
      return h;
    d = 1'($urandom_range(1));
    h.direction  = d;
    h.seq_number = snd_next[d];
    h.ack_flag   = ($urandom_range(9) != 0);
    h.syn_flag   = ($urandom_range(29) == 0);
    h.fin_flag   = ($urandom_range(29) == 0);
    h.ip_header_words  = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'd5;
    h.tcp_header_words = ($urandom_range(1) == 0) ? 4'($urandom_range(5, 15)) : 4'd8;
    case ($urandom_range(9))
      0:       h.payload_bytes = '0;
      1:       h.payload_bytes = 16'($urandom_range(65535));
      default: h.payload_bytes = 16'($urandom_range(1460));
    endcase
    // ack lags what the other side has sent; a big lag now and then
    if ($urandom_range(19) == 0)
      h.ack_number = snd_next[~d] - $urandom_range(20000);
    else
      h.ack_number = snd_next[~d] - $urandom_range(3000);
    snd_next[d] = snd_next[d] + h.payload_bytes + h.syn_flag + h.fin_flag;
    clock_us    = clock_us + $urandom_range(2000);
    h.arrival_time = clock_us;
    return h;
  endfunction

  task automatic send_hdr(input tsir_hdr_t h);
    while (!steady && $urandom_range(99) < 32) begin
      hdr_ch.valid <= 1'b0;
      @(posedge clk);
    end
    hdr_ch.valid <= 1'b1;
    hdr_ch.data  <= h;
    @(posedge clk);
    while (!hdr_ch.ready)
      @(posedge clk);
  endtask

  task automatic send_traffic(input int count);
    for (int i = 0; i < count; i++)
      send_hdr(traffic_item());
  endtask

  // pending is read after the checker has seen the last transfer, so it never undercounts
  task automatic wait_idle();
    hdr_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_ack_cap(input logic [15:0] value);
    ack_cap_we    <= 1'b1;
    ack_cap_wdata <= value;
    @(posedge clk);
    ack_cap_we    <= 1'b0;
  endtask

  initial begin
    rst           <= 1'b1;
    ack_cap_we    <= 1'b0;
    ack_cap_wdata <= '0;
    hdr_ch.valid  <= 1'b0;
    hdr_ch.data   <= '0;
    snd_next[0]   = $urandom;
    snd_next[1]   = $urandom;
    clock_us      = 48'hFFFF_FFFE_0000;  // wraps during the run
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset cap of 7500
    // first packet carries ACK: sets the peer's base before it speaks
    send_hdr(hdr_item(0, 32'hFFFF_FF00, 32'h7000_0000, F_ACK | F_SYN, 5, 10, 0, 100));
    send_hdr(hdr_item(1, 32'h0000_1000, 32'hFFFF_FF01, F_ACK | F_SYN, 5, 10, 0, 150));
    send_hdr(hdr_item(0, 32'hFFFF_FF01, 32'h7000_0010, F_ACK, 5, 5, 0, 200));
    send_hdr(hdr_item(0, 32'hFFFF_FF01, 32'h7000_0010, F_ACK, 5, 5, 1460, 300));
    send_hdr(hdr_item(1, 32'h0000_1001, 32'h0000_04B5, F_ACK, 5, 5, 0, 400));
    // advance equal to the cap, then one below it
    send_hdr(hdr_item(1, 32'h0000_1001, 32'h0000_2201, F_ACK, 5, 5, 0, 500));
    send_hdr(hdr_item(1, 32'h0000_1001, 32'h0000_3F4C, F_ACK, 5, 5, 0, 600));
    // ack going backwards, then no ACK, then ACK after a packet without it
    send_hdr(hdr_item(1, 32'h0000_1001, 32'h0000_3F00, F_ACK, 5, 5, 0, 700));
    send_hdr(hdr_item(1, 32'h0000_1001, 32'h0000_5000, F_NONE, 5, 5, 0, 800));
    send_hdr(hdr_item(1, 32'h0000_1001, 32'h0000_6000, F_ACK, 5, 5, 0, 900));
    // time going backwards
    send_hdr(hdr_item(0, 32'h0000_05B5, 32'h7000_0010, F_ACK, 5, 5, 100, 50));
    send_hdr(hdr_item(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, F_ACK | F_SYN | F_FIN, 15, 15,
                      16'hFFFF, 48'hFFFF_FFFF_FFFF));
    // header words below five, zero size
    send_hdr(hdr_item(0, 32'h0000_0000, 32'h0000_0000, F_NONE, 0, 0, 0, 0));
    send_hdr(hdr_item(1, 32'h0000_1001, 32'h0000_6000, F_FIN, 4, 3, 1, 1000));
    send_hdr(hdr_item(1, 32'hAAAA_AAAA, 32'h5555_5555, F_ACK, 10, 6, 16'h5555,
                      48'hAAAA_AAAA_AAAA));
    send_hdr(hdr_item(0, 32'h5555_5555, 32'hAAAA_AAAA, F_ACK, 6, 10, 16'hAAAA,
                      48'h5555_5555_5555));
    wait_idle();

    write_ack_cap(16'hFFFF);
    send_traffic(150);
    wait_idle();

    // receiver holds off while headers keep coming
    hold_req = 1'b1;
    steady   = 1'b1;
    send_traffic(60);
    steady   = 1'b0;
    wait_idle();

    write_ack_cap(16'd1);
    send_traffic(100);
    wait_idle();

    write_ack_cap(16'd0);
    send_traffic(60);
    wait_idle();

    // full rate, no idling on either side
    write_ack_cap(16'd1500);
    steady = 1'b1;
    send_traffic(150);
    wait_idle();
    steady = 1'b0;

    write_ack_cap(16'($urandom_range(2, 65534)));
    send_traffic(150);
    wait_idle();
    repeat (10) @(posedge clk);

    if (fail_count == 0)
      $display("tcp_segment_interval_record_unit test passed");
    else
      $display("tcp_segment_interval_record_unit test failed");
    $finish;
  end

endmodule
